### src/windowed_threshold_event_filter_assert.svh
// Assertion macros for the windowed threshold event filter checker.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef WINDOWED_THRESHOLD_EVENT_FILTER_ASSERT_SVH
`define WINDOWED_THRESHOLD_EVENT_FILTER_ASSERT_SVH

// same-cycle implication
`define WTEF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WTEF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/wtef_pkg.sv
// Shared widths, history entry type and register indexes for the
// windowed threshold event filter. No dependencies.
`default_nettype none

package wtef_pkg;

    localparam int HIST_ENTRIES = 16;
    localparam int HIST_AW      = (HIST_ENTRIES > 1) ? $clog2(HIST_ENTRIES) : 1;

    localparam int HOST_W   = 10;
    localparam int CORE_W   = 8;
    localparam int FREQ_W   = 24;
    localparam int STAMP_W  = 32;
    localparam int COUNT_W  = 16;
    localparam int WIN_W    = 20;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_THR   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SIDE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FIRE_LIMIT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_WIN   = CFG_IDX_W'(3);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [HOST_W-1:0]  host;
        logic [CORE_W-1:0]  core;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } hist_entry_t;

    localparam int ENTRY_W = $bits(hist_entry_t);

endpackage

`default_nettype wire

### src/wtef_hist_ram.sv
// History table storage: simple dual-port RAM, one write and one
// registered read per cycle. No package dependency.
`default_nettype none

module wtef_hist_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### src/windowed_threshold_event_filter.sv
// Windowed threshold event filter: top level with the scan/update sequencer.
// Depends on wtef_pkg and wtef_hist_ram.
//
// - Input s_*: one frequency sample per request (host, core, freq, timestamp).
//   Result m_*: exactly one result per sample, in order.
// - Config cfg_*: single-cycle writes, index 0 threshold, 1 high_side,
//   2 fire count, 3 time window; other indexes ignored. Write only while idle.
// - Non-counting sample: table untouched, result goes from ST_RESP into the
//   output register, next request taken once the sequencer is back in ST_IDLE.
// - Crossing sample: scans the history RAM one entry per cycle (stops at the
//   first key match), then updates count/stamp and writes a hit back. A miss
//   fires at once if the fire limit is 0 or 1, else takes a free entry or is
//   dropped when the table is full. The result goes out through ST_RESP; the
//   scan pace is set by the single RAM read port. One item in flight, so a
//   write-back always lands before the next scan reads the RAM.
// - The output register holds a result while m_ready is low; the next request
//   is still accepted and worked on, and waits once its own result is ready.
// - Reset (aresetn low, synchronous) clears all entry valid bits, the
//   sequencer and the output, and loads the register defaults.
`default_nettype none

module windowed_threshold_event_filter (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [wtef_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wtef_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [wtef_pkg::HOST_W-1:0]         s_host_id,
    input  logic [wtef_pkg::CORE_W-1:0]         s_core,
    input  logic [wtef_pkg::FREQ_W-1:0]         s_freq_khz,
    input  logic [wtef_pkg::STAMP_W-1:0]        s_timestamp_s,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_crossed,
    output logic                                m_event_fired,
    output logic [wtef_pkg::COUNT_W-1:0]        m_count_seen,
    output logic                                m_dropped_full
);

    import wtef_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD,
        ST_FIN,
        ST_RESP
    } fsm_state_t;

    fsm_state_t state_reg, state_next;

    // configuration
    logic [FREQ_W-1:0]  thr_reg, thr_next;
    logic               high_reg, high_next;
    logic [COUNT_W-1:0] maxc_reg, maxc_next;
    logic [WIN_W-1:0]   win_reg, win_next;

    // entry valid bits live in flops so reset clears them at once
    logic [HIST_ENTRIES-1:0] valid_reg, valid_next;

    // request being worked on
    logic [HOST_W-1:0]  key_host_reg, key_host_next;
    logic [CORE_W-1:0]  key_core_reg, key_core_next;
    logic [STAMP_W-1:0] key_ts_reg, key_ts_next;

    // scan pipeline: issue address, then check the returned entry
    logic [HIST_AW:0]   issue_idx_reg, issue_idx_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [HIST_AW-1:0] chk_idx_reg, chk_idx_next;
    logic               hit_found_reg, hit_found_next;
    logic [HIST_AW-1:0] hit_idx_reg, hit_idx_next;
    logic               free_found_reg, free_found_next;
    logic [HIST_AW-1:0] free_idx_reg, free_idx_next;
    logic [COUNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [STAMP_W-1:0] hit_stamp_reg, hit_stamp_next;

    // updated count/stamp of the hit entry
    logic [COUNT_W-1:0] upd_cnt_reg, upd_cnt_next;
    logic [STAMP_W-1:0] upd_stamp_reg, upd_stamp_next;

    // finished result, waiting for the output register
    logic               res_crossed_reg, res_crossed_next;
    logic               res_fired_reg, res_fired_next;
    logic [COUNT_W-1:0] res_count_reg, res_count_next;
    logic               res_dropped_reg, res_dropped_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic               m_crossed_reg, m_crossed_next;
    logic               m_fired_reg, m_fired_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic               m_dropped_reg, m_dropped_next;

    // RAM ports
    logic               ram_wr_en;
    logic [HIST_AW-1:0] ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [HIST_AW-1:0] ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;
    hist_entry_t        rd_entry;
    hist_entry_t        wr_entry;

    // scan / update helpers
    logic               crossed_now;
    logic               chk_valid_bit;
    logic               chk_match;
    logic               chk_last;
    logic [STAMP_W:0]   limit;
    logic               expired;
    logic               fire_hit;

    assign rd_entry = hist_entry_t'(ram_rd_data);

    wtef_hist_ram #(
        .DEPTH (HIST_ENTRIES),
        .WIDTH (ENTRY_W),
        .AW    (HIST_AW)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // threshold compare on the incoming sample
    assign crossed_now = high_reg ? (s_freq_khz >= thr_reg) : (s_freq_khz <= thr_reg);

    // returned entry compare; valid bit picked by the index it was read from
    assign chk_valid_bit = valid_reg[chk_idx_reg];
    assign chk_match     = chk_vld_reg && chk_valid_bit
                           && (rd_entry.host == key_host_reg)
                           && (rd_entry.core == key_core_reg);
    assign chk_last      = chk_vld_reg && (chk_idx_reg == HIST_AW'(HIST_ENTRIES - 1));

    // window check, computed wide so it never wraps
    assign limit   = {1'b0, hit_stamp_reg} + (STAMP_W + 1)'(win_reg);
    assign expired = limit < {1'b0, key_ts_reg};

    assign fire_hit = upd_cnt_reg >= maxc_reg;

    always_comb begin
        state_next       = state_reg;
        thr_next         = thr_reg;
        high_next        = high_reg;
        maxc_next        = maxc_reg;
        win_next         = win_reg;
        valid_next       = valid_reg;
        key_host_next    = key_host_reg;
        key_core_next    = key_core_reg;
        key_ts_next      = key_ts_reg;
        issue_idx_next   = issue_idx_reg;
        chk_vld_next     = 1'b0;
        chk_idx_next     = chk_idx_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        hit_cnt_next     = hit_cnt_reg;
        hit_stamp_next   = hit_stamp_reg;
        upd_cnt_next     = upd_cnt_reg;
        upd_stamp_next   = upd_stamp_reg;
        res_crossed_next = res_crossed_reg;
        res_fired_next   = res_fired_reg;
        res_count_next   = res_count_reg;
        res_dropped_next = res_dropped_reg;
        m_valid_next     = m_valid_reg;
        m_crossed_next   = m_crossed_reg;
        m_fired_next     = m_fired_reg;
        m_count_next     = m_count_reg;
        m_dropped_next   = m_dropped_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = hit_idx_reg;
        wr_entry    = '{host: key_host_reg, core: key_core_reg,
                        count: upd_cnt_reg, stamp: upd_stamp_reg};
        ram_rd_en   = 1'b0;
        ram_rd_addr = issue_idx_reg[HIST_AW-1:0];

        // config writes, taken in any state
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FREQ_THR:   thr_next  = cfg_wdata[FREQ_W-1:0];
                CFG_HIGH_SIDE:  high_next = cfg_wdata[0];
                CFG_FIRE_LIMIT: maxc_next = cfg_wdata[COUNT_W-1:0];
                CFG_TIME_WIN:   win_next  = cfg_wdata[WIN_W-1:0];
                default: ;
            endcase
        end

        // output register drains on handshake
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_host_next = s_host_id;
                    key_core_next = s_core;
                    key_ts_next   = s_timestamp_s;
                    if (crossed_now) begin
                        issue_idx_next  = '0;
                        hit_found_next  = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = ST_SCAN;
                    end else begin
                        res_crossed_next = 1'b0;
                        res_fired_next   = 1'b0;
                        res_count_next   = '0;
                        res_dropped_next = 1'b0;
                        state_next       = ST_RESP;
                    end
                end
            end

            ST_SCAN: begin
                // issue the next read unless this cycle already hit or every entry was issued
                if (!chk_match && (issue_idx_reg != (HIST_AW + 1)'(HIST_ENTRIES))) begin
                    ram_rd_en      = 1'b1;
                    chk_vld_next   = 1'b1;
                    chk_idx_next   = issue_idx_reg[HIST_AW-1:0];
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                if (chk_vld_reg && !chk_valid_bit && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = chk_idx_reg;
                end
                if (chk_match) begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = chk_idx_reg;
                    hit_cnt_next   = rd_entry.count;
                    hit_stamp_next = rd_entry.stamp;
                end
                if (chk_match || chk_last) begin
                    state_next = ST_UPD;
                end
            end

            ST_UPD: begin
                if (expired) begin
                    upd_cnt_next   = COUNT_W'(1);
                    upd_stamp_next = key_ts_reg;
                end else begin
                    upd_cnt_next   = (hit_cnt_reg != COUNT_MAX) ? hit_cnt_reg + 1'b1
                                                                : hit_cnt_reg;
                    upd_stamp_next = hit_stamp_reg;
                end
                state_next = ST_FIN;
            end

            ST_FIN: begin
                res_crossed_next = 1'b1;
                res_fired_next   = 1'b0;
                res_dropped_next = 1'b0;
                if (hit_found_reg) begin
                    ram_wr_en      = 1'b1;
                    ram_wr_addr    = hit_idx_reg;
                    res_count_next = upd_cnt_reg;
                    if (fire_hit) begin
                        res_fired_next           = 1'b1;
                        valid_next[hit_idx_reg]  = 1'b0;
                    end
                end else if (maxc_reg <= COUNT_W'(1)) begin
                    // new key fires at once, nothing stored
                    res_fired_next = 1'b1;
                    res_count_next = COUNT_W'(1);
                end else if (free_found_reg) begin
                    ram_wr_en                = 1'b1;
                    ram_wr_addr              = free_idx_reg;
                    wr_entry.count           = COUNT_W'(1);
                    wr_entry.stamp           = key_ts_reg;
                    valid_next[free_idx_reg] = 1'b1;
                    res_count_next           = COUNT_W'(1);
                end else begin
                    // table full
                    res_dropped_next = 1'b1;
                    res_count_next   = '0;
                end
                state_next = ST_RESP;
            end

            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_crossed_next = res_crossed_reg;
                    m_fired_next   = res_fired_reg;
                    m_count_next   = res_count_reg;
                    m_dropped_next = res_dropped_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        ram_wr_data = wr_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= '0;
            high_reg    <= 1'b1;
            maxc_reg    <= COUNT_W'(1);
            win_reg     <= '0;
            valid_reg   <= '0;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            thr_reg     <= thr_next;
            high_reg    <= high_next;
            maxc_reg    <= maxc_next;
            win_reg     <= win_next;
            valid_reg   <= valid_next;
            chk_vld_reg <= chk_vld_next;
            m_valid_reg <= m_valid_next;
        end
        key_host_reg    <= key_host_next;
        key_core_reg    <= key_core_next;
        key_ts_reg      <= key_ts_next;
        issue_idx_reg   <= issue_idx_next;
        chk_idx_reg     <= chk_idx_next;
        hit_found_reg   <= hit_found_next;
        hit_idx_reg     <= hit_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        hit_cnt_reg     <= hit_cnt_next;
        hit_stamp_reg   <= hit_stamp_next;
        upd_cnt_reg     <= upd_cnt_next;
        upd_stamp_reg   <= upd_stamp_next;
        res_crossed_reg <= res_crossed_next;
        res_fired_reg   <= res_fired_next;
        res_count_reg   <= res_count_next;
        res_dropped_reg <= res_dropped_next;
        m_crossed_reg   <= m_crossed_next;
        m_fired_reg     <= m_fired_next;
        m_count_reg     <= m_count_next;
        m_dropped_reg   <= m_dropped_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_crossed      = m_crossed_reg;
    assign m_event_fired  = m_fired_reg;
    assign m_count_seen   = m_count_reg;
    assign m_dropped_full = m_dropped_reg;

endmodule

`default_nettype wire

### src/wtef_checker.sv
// Port-level checker for the windowed threshold event filter, bound to the
// top level. Depends on wtef_pkg and windowed_threshold_event_filter_assert.svh.
`default_nettype none

`include "windowed_threshold_event_filter_assert.svh"

module wtef_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_crossed,
    input  logic                                m_event_fired,
    input  logic [wtef_pkg::COUNT_W-1:0]        m_count_seen,
    input  logic                                m_dropped_full
);

    // stalled result holds
    `WTEF_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_count_seen) && $stable(m_event_fired), "result changed while stalled")

    // a sample off the counting side leaves every other field at zero
    `WTEF_ASSERT_NOW(a_no_cross_zero, m_valid && !m_crossed, !m_event_fired && !m_dropped_full && (m_count_seen == '0), "non-crossing result has nonzero fields")

    // a dropped sample neither fires nor counts
    `WTEF_ASSERT_NOW(a_drop_clean, m_valid && m_dropped_full, m_crossed && !m_event_fired && (m_count_seen == '0), "dropped result inconsistent")

    // a fired event always carries a nonzero count
    `WTEF_ASSERT_NOW(a_fire_count, m_valid && m_event_fired, m_crossed && (m_count_seen != '0), "event fired with zero count")

endmodule

bind windowed_threshold_event_filter wtef_checker u_wtef_checker (.*);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for windowed_threshold_event_filter: a directed stimulus table,
// then randomized phases under several register settings, all scored by a local predictor.
// Depends on wtef_pkg and the filter RTL.

module testbench;
    import wtef_pkg::*;

    // Unused register index; writes to it must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(7);

    localparam logic [FREQ_W-1:0] FREQ_TOP  = '1;
    localparam logic [WIN_W-1:0]  WIN_TOP   = '1;
    localparam int                PAD_SIDE  = CFG_DATA_W - 1;
    localparam int                PAD_COUNT = CFG_DATA_W - COUNT_W;
    localparam int                PAD_WIN   = CFG_DATA_W - WIN_W;

    // Cycles without any accepted request before the run is declared hung.
    // Worst correct gap is a full table scan plus a receiver stall.
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASES        = 9;
    localparam int PHASE_SAMPLES = 110;

    typedef struct packed {
        logic [HOST_W-1:0]  host;
        logic [CORE_W-1:0]  core;
        logic [FREQ_W-1:0]  freq;
        logic [STAMP_W-1:0] stamp;
    } sample_t;

    typedef struct packed {
        logic [FREQ_W-1:0]  thr;
        logic               high_side;
        logic [COUNT_W-1:0] fire_limit;
        logic [WIN_W-1:0]   window;
    } settings_t;

    typedef struct packed {
        logic               crossed;
        logic               fired;
        logic [COUNT_W-1:0] count;
        logic               dropped;
    } outcome_t;

    typedef enum logic {ROW_SETTINGS, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        settings_t cfg;
        sample_t   smp;
        logic      typed;   // expectation written in the row, not predicted
        outcome_t  want;
    } plan_row_t;

    // DUT connections
    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [HOST_W-1:0]     s_host_id;
    logic [CORE_W-1:0]     s_core;
    logic [FREQ_W-1:0]     s_freq_khz;
    logic [STAMP_W-1:0]    s_timestamp_s;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_crossed;
    logic                  m_event_fired;
    logic [COUNT_W-1:0]    m_count_seen;
    logic                  m_dropped_full;

    // Predictor copy of the registers and of the history table
    settings_t          cur_cfg;
    logic               hist_valid [HIST_ENTRIES];
    logic [HOST_W-1:0]  hist_host  [HIST_ENTRIES];
    logic [CORE_W-1:0]  hist_core  [HIST_ENTRIES];
    logic [COUNT_W-1:0] hist_count [HIST_ENTRIES];
    logic [STAMP_W-1:0] hist_stamp [HIST_ENTRIES];

    outcome_t  outcome_q[$];    // expected results, oldest first
    plan_row_t plan_q[$];       // directed stimulus table
    outcome_t  oldest;

    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned quiet_cycles = 0;
    int unsigned errors       = 0;
    int unsigned n_samples    = 0;
    int unsigned n_crossed    = 0;
    int unsigned n_fired      = 0;
    int unsigned n_dropped    = 0;
    int unsigned n_settings   = 0;
    logic [STAMP_W-1:0] clock_s = '0;   // running time base for random samples

    windowed_threshold_event_filter i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_host_id      (s_host_id),
        .s_core         (s_core),
        .s_freq_khz     (s_freq_khz),
        .s_timestamp_s  (s_timestamp_s),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_crossed      (m_crossed),
        .m_event_fired  (m_event_fired),
        .m_count_seen   (m_count_seen),
        .m_dropped_full (m_dropped_full)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor: threshold test, then table lookup / insert / fire.
    // Updates the local table exactly as the block should.
    // ------------------------------------------------------------------
    function automatic outcome_t next_outcome(sample_t s);
        outcome_t           o;
        int                 hit;
        int                 free_idx;
        logic [STAMP_W:0]   horizon;    // one extra bit: stamp + window must not wrap
        o        = '0;
        hit      = -1;
        free_idx = -1;
        o.crossed = cur_cfg.high_side ? (s.freq >= cur_cfg.thr) : (s.freq <= cur_cfg.thr);
        if (!o.crossed) return o;

        // Lowest matching valid entry wins; remember the lowest free one too
        for (int i = 0; i < HIST_ENTRIES; i++) begin
            if (hist_valid[i]) begin
                if (hit < 0 && hist_host[i] == s.host && hist_core[i] == s.core) hit = i;
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end

        if (hit >= 0) begin
            horizon = {1'b0, hist_stamp[hit]} + (STAMP_W + 1)'(cur_cfg.window);
            if (horizon < {1'b0, s.stamp}) begin
                // window ran out: start counting again from this sample
                hist_count[hit] = COUNT_W'(1);
                hist_stamp[hit] = s.stamp;
            end else if (hist_count[hit] != COUNT_MAX) begin
                hist_count[hit] = hist_count[hit] + 1'b1;
            end
            o.count = hist_count[hit];
            if (o.count >= cur_cfg.fire_limit) begin
                o.fired         = 1'b1;
                hist_valid[hit] = 1'b0;
            end
        end else if (cur_cfg.fire_limit <= COUNT_W'(1)) begin
            // single crossing is enough: fire without storing the key
            o.fired = 1'b1;
            o.count = COUNT_W'(1);
        end else if (free_idx >= 0) begin
            hist_valid[free_idx] = 1'b1;
            hist_host[free_idx]  = s.host;
            hist_core[free_idx]  = s.core;
            hist_count[free_idx] = COUNT_W'(1);
            hist_stamp[free_idx] = s.stamp;
            o.count              = COUNT_W'(1);
        end else begin
            o.dropped = 1'b1;
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    function automatic void add_settings(logic [FREQ_W-1:0] thr, logic side,
                                         logic [COUNT_W-1:0] maxc, logic [WIN_W-1:0] win);
        plan_row_t r;
        r                 = '0;
        r.kind            = ROW_SETTINGS;
        r.cfg.thr         = thr;
        r.cfg.high_side   = side;
        r.cfg.fire_limit  = maxc;
        r.cfg.window      = win;
        plan_q.push_back(r);
    endfunction

    function automatic void add_typed(logic [HOST_W-1:0] h, logic [CORE_W-1:0] c,
                                      logic [FREQ_W-1:0] f, logic [STAMP_W-1:0] t,
                                      logic typed, logic x, logic fi,
                                      logic [COUNT_W-1:0] cnt, logic dr);
        plan_row_t r;
        r              = '0;
        r.kind         = ROW_SAMPLE;
        r.smp.host     = h;
        r.smp.core     = c;
        r.smp.freq     = f;
        r.smp.stamp    = t;
        r.typed        = typed;
        r.want.crossed = x;
        r.want.fired   = fi;
        r.want.count   = cnt;
        r.want.dropped = dr;
        plan_q.push_back(r);
    endfunction

    function automatic void add_sample(logic [HOST_W-1:0] h, logic [CORE_W-1:0] c,
                                       logic [FREQ_W-1:0] f, logic [STAMP_W-1:0] t);
        add_typed(h, c, f, t, 1'b0, 1'b0, 1'b0, '0, 1'b0);
    endfunction

    // ------------------------------------------------------------------
    // Drivers. All drives are nonblocking at the rising edge; every task
    // is entered and left right after a rising edge.
    // ------------------------------------------------------------------

    // Present one request, hold it until accepted, then record its expectation.
    // Leaves s_valid high so back-to-back requests need no second assignment.
    task automatic send_sample(input sample_t smp, input logic typed, input outcome_t want);
        outcome_t got;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_host_id     <= smp.host;
        s_core        <= smp.core;
        s_freq_khz    <= smp.freq;
        s_timestamp_s <= smp.stamp;
        do @(posedge aclk); while (!s_ready);
        got = next_outcome(smp);
        outcome_q.push_back(typed ? want : got);
        n_samples++;
    endtask

    // Stop sending, wait for every pending result, then let the block settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (HIST_ENTRIES + 6) @(posedge aclk);
    endtask

    // Write all four registers (junk in the unused upper data bits) and the
    // spare index, one write per cycle. Only called while the block is idle.
    task automatic apply_settings(input settings_t c);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FREQ_THR;
        cfg_wdata <= c.thr;
        @(posedge aclk);
        cfg_index <= CFG_HIGH_SIDE;
        cfg_wdata <= {PAD_SIDE'($urandom), c.high_side};
        @(posedge aclk);
        cfg_index <= CFG_FIRE_LIMIT;
        cfg_wdata <= {PAD_COUNT'($urandom), c.fire_limit};
        @(posedge aclk);
        cfg_index <= CFG_TIME_WIN;
        cfg_wdata <= {PAD_WIN'($urandom), c.window};
        @(posedge aclk);
        cfg_index <= CFG_SPARE_IDX;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
        n_settings++;
    endtask

    // Empty the history table: with a fire limit of 0 and every frequency
    // crossing, one request per stored key makes that entry fire and free itself.
    task automatic flush_history();
        settings_t c;
        sample_t   s;
        wait_drained();
        c.thr        = '0;
        c.high_side  = 1'b1;
        c.fire_limit = '0;
        c.window     = '0;
        apply_settings(c);
        for (int i = 0; i < HIST_ENTRIES; i++) begin
            if (hist_valid[i]) begin
                s.host  = hist_host[i];
                s.core  = hist_core[i];
                s.freq  = FREQ_W'($urandom);
                s.stamp = clock_s;
                send_sample(s, 1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Receiver: random backpressure per the current idling pattern
    always @(posedge aclk) m_ready <= ($urandom_range(99) >= rcv_idle_pct);

    // Every accepted result is compared against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                $error("result with no pending sample");
                errors++;
            end else begin
                oldest = outcome_q.pop_front();
                check_field("crossed",      oldest.crossed, m_crossed);
                check_field("event_fired",  oldest.fired,   m_event_fired);
                check_field("count_seen",   oldest.count,   m_count_seen);
                check_field("dropped_full", oldest.dropped, m_dropped_full);
            end
            n_crossed += m_crossed;
            n_fired   += m_event_fired;
            n_dropped += m_dropped_full;
        end
    end

    // Watchdog: count cycles in which neither channel moves a request
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $error("no request accepted for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        settings_t          ph_cfg;
        sample_t            smp;
        logic [HOST_W-1:0]  pool_host [32];
        logic [CORE_W-1:0]  pool_core [32];
        int unsigned        pool_size;
        int unsigned        pick;
        int unsigned        span;
        int unsigned        ofs;
        int unsigned        idx;

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_host_id     = '0;
        s_core        = '0;
        s_freq_khz    = '0;
        s_timestamp_s = '0;

        // register defaults after reset, table empty
        cur_cfg.thr        = '0;
        cur_cfg.high_side  = 1'b1;
        cur_cfg.fire_limit = COUNT_W'(1);
        cur_cfg.window     = '0;
        for (int i = 0; i < HIST_ENTRIES; i++) hist_valid[i] = 1'b0;

        // sender idle odds 16 percent, receiver 73 percent
        snd_idle_pct = 16;
        rcv_idle_pct = 73;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed table ---
        // Reset defaults: threshold 0 on the high side, fire limit 1, so every
        // sample crosses and fires at once with a count of 1.
        add_typed('0, '0, '0, '0,                 1'b1, 1'b1, 1'b1, 16'd1, 1'b0);
        add_typed('1, '1, '1, 32'hFFFF_FFFF,      1'b1, 1'b1, 1'b1, 16'd1, 1'b0);
        // Top threshold, high side: only the top frequency crosses
        add_settings(FREQ_TOP, 1'b1, 16'd1, '0);
        add_typed(10'd3, 8'd4, FREQ_TOP - 1'b1, 32'd10, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0);
        add_typed(10'd3, 8'd4, FREQ_TOP, 32'd11,        1'b1, 1'b1, 1'b1, 16'd1, 1'b0);
        // Zero threshold, low side: only frequency 0 crosses
        add_settings('0, 1'b0, 16'd1, '0);
        add_typed(10'd3, 8'd4, 24'd1, 32'd12,           1'b1, 1'b0, 1'b0, 16'd0, 1'b0);
        add_typed(10'd3, 8'd4, '0, 32'd13,              1'b1, 1'b1, 1'b1, 16'd1, 1'b0);
        // Window of 10 s, three crossings to fire: count, expire and restart
        add_settings(24'd5_000_000, 1'b1, 16'd3, 20'd10);
        add_sample(10'd5, 8'd3, 24'd6_000_000, 32'd100);
        add_sample(10'd5, 8'd3, 24'd6_000_000, 32'd105);
        add_sample(10'd5, 8'd3, 24'd6_000_000, 32'd116);    // 100 + 10 < 116: restart
        add_sample(10'd5, 8'd3, 24'd5_000_000, 32'd120);    // threshold itself counts
        // Lower the fire limit to zero under a stored count of 2: next crossing
        // fires, sitting exactly at the window edge (116 + 10 == 126)
        add_settings(24'd5_000_000, 1'b1, 16'd0, 20'd10);
        add_sample(10'd5, 8'd3, 24'd7_000_000, 32'd126);
        add_typed(10'd6, 8'd3, 24'd5_000_000, 32'd127,  1'b1, 1'b1, 1'b1, 16'd1, 1'b0);
        add_typed(10'd6, 8'd3, 24'd4_999_999, 32'd128,  1'b1, 1'b0, 1'b0, 16'd0, 1'b0);
        // Fill the table with distinct keys, then one more key is dropped.
        // The first key sits near the top of time so stamp + window would wrap.
        add_settings(FREQ_TOP, 1'b0, COUNT_MAX, WIN_TOP);
        for (int i = 0; i < HIST_ENTRIES; i++)
            add_sample(HOST_W'(100 + i), CORE_W'(i), FREQ_W'($urandom),
                       (i == 0) ? 32'hFFFF_FFF0 : STAMP_W'(1000 + i));
        add_typed(10'd999, 8'd7, '0, 32'd2000,          1'b1, 1'b1, 1'b0, 16'd0, 1'b1);
        add_sample(10'd100, 8'd0, '0, 32'hFFFF_FFFF);       // still inside its window

        foreach (plan_q[k]) begin
            if (plan_q[k].kind == ROW_SETTINGS) begin
                wait_drained();
                apply_settings(plan_q[k].cfg);
            end else begin
                send_sample(plan_q[k].smp, plan_q[k].typed, plan_q[k].want);
            end
        end
        flush_history();

        // --- random phases ---
        for (int p = 0; p < PHASES; p++) begin
            // idling: sender light / receiver heavy, then swapped, then none
            case (p / 3)
                0:       begin snd_idle_pct = 16; rcv_idle_pct = 73; end
                1:       begin snd_idle_pct = 73; rcv_idle_pct = 16; end
                default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
            endcase

            ph_cfg.thr       = FREQ_W'($urandom);
            ph_cfg.high_side = 1'($urandom_range(1));
            ph_cfg.window    = WIN_W'($urandom_range(0, 1000));
            case (p)
                0: begin
                    ph_cfg.high_side = 1'b1; ph_cfg.fire_limit = COUNT_W'(3);
                    ph_cfg.window = WIN_W'(20);
                end
                1: begin
                    ph_cfg.high_side = 1'b0; ph_cfg.fire_limit = COUNT_W'(2);
                    ph_cfg.window = '0;
                end
                2: begin
                    ph_cfg.thr = '0; ph_cfg.high_side = 1'b1;
                    ph_cfg.fire_limit = COUNT_W'(4); ph_cfg.window = WIN_TOP;
                end
                3: begin
                    ph_cfg.thr = FREQ_TOP; ph_cfg.high_side = 1'b0;
                    ph_cfg.fire_limit = '0; ph_cfg.window = WIN_W'($urandom);
                end
                4: ph_cfg.fire_limit = COUNT_W'(1);
                5: begin   // more keys than entries: table fills and drops
                    ph_cfg.high_side = 1'b1; ph_cfg.fire_limit = COUNT_MAX;
                    ph_cfg.window = WIN_W'(50);
                end
                6: begin
                    ph_cfg.high_side = 1'b0; ph_cfg.fire_limit = COUNT_W'(5);
                    ph_cfg.window = WIN_W'(5);
                end
                7: ph_cfg.fire_limit = COUNT_W'($urandom_range(2, 8));
                default: begin
                    ph_cfg.thr = FREQ_TOP; ph_cfg.high_side = 1'b1;
                    ph_cfg.fire_limit = COUNT_W'(2); ph_cfg.window = WIN_W'(100);
                end
            endcase
            wait_drained();
            apply_settings(ph_cfg);

            // small pool of keys so that keys recur and windows matter
            pool_size = (p == 5) ? 24 : $urandom_range(2, 20);
            for (int i = 0; i < pool_size; i++) begin
                pool_host[i] = HOST_W'($urandom);
                pool_core[i] = CORE_W'($urandom);
            end

            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                // now and then hold off until every pending result is back
                if ($urandom_range(49) == 0) wait_drained();

                if ($urandom_range(99) < 10) begin
                    smp.host = HOST_W'($urandom);
                    smp.core = CORE_W'($urandom);
                end else begin
                    idx      = $urandom_range(0, pool_size - 1);
                    smp.host = pool_host[idx];
                    smp.core = pool_core[idx];
                end

                // frequency: anywhere, on the counting side (often right at
                // the threshold), or just past it on the other side
                pick = $urandom_range(99);
                span = cur_cfg.high_side ? 32'(FREQ_TOP - cur_cfg.thr) : 32'(cur_cfg.thr);
                if (pick < 35) begin
                    smp.freq = FREQ_W'($urandom);
                end else if (pick < 85) begin
                    ofs = (pick < 60) ? $urandom_range(0, span)
                                      : $urandom_range(0, (span < 2) ? span : 2);
                    smp.freq = cur_cfg.high_side ? cur_cfg.thr + FREQ_W'(ofs)
                                                 : cur_cfg.thr - FREQ_W'(ofs);
                end else if (cur_cfg.high_side) begin
                    smp.freq = (cur_cfg.thr == '0) ? FREQ_W'($urandom) : cur_cfg.thr - 1'b1;
                end else begin
                    smp.freq = (cur_cfg.thr == FREQ_TOP) ? FREQ_W'($urandom)
                                                         : cur_cfg.thr + 1'b1;
                end

                // time: mostly small steps inside the window, some steps of
                // about one window, a few large jumps and stray stamps
                pick = $urandom_range(99);
                if (pick < 65)
                    clock_s = clock_s + $urandom_range(0, cur_cfg.window / 2 + 1);
                else if (pick < 85)
                    clock_s = clock_s + cur_cfg.window + $urandom_range(0, 2);
                else if (pick < 95)
                    clock_s = clock_s + $urandom;
                smp.stamp = (pick >= 97) ? STAMP_W'($urandom) : clock_s;

                send_sample(smp, 1'b0, '0);
            end
            flush_history();
        end

        wait_drained();

        $display("Summary: %0d samples, %0d crossings, %0d events, %0d table-full drops",
                 n_samples, n_crossed, n_fired, n_dropped);
        $display("Summary: %0d register settings, three idling patterns, table fill and flush",
                 n_settings);
        if (errors == 0 && outcome_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/wtef_pkg.sv
src/wtef_hist_ram.sv
src/windowed_threshold_event_filter.sv
src/wtef_checker.sv
tb/testbench.sv
